>>> rtl/rvjc_pkg.sv
package rvjc_pkg;

  localparam int DataW   = 32;
  localparam int RegIdxW = 3;
  localparam int NumOff  = 3;
  localparam int NumQuat = 4;
  // bilinear term: 64-bit product shifted down by 29
  localparam int TermShift = 29;
  localparam int TermW     = 2 * DataW - TermShift;
  // matrix entry: sum of three terms
  localparam int MatW = TermW + 1;
  // quaternion derivative split into a signed high part and an unsigned low part
  localparam int LoW    = 15;
  localparam int HiW    = DataW - LoW;
  localparam int ProdAW = MatW + HiW;
  localparam int ProdBW = MatW + LoW + 1;
  localparam int FullW  = ProdAW + LoW;
  localparam int ProdShift = 30;
  localparam int ProdW  = FullW - ProdShift;
  localparam int SumW   = ProdW + 3;

  localparam int CfgBusyCycles = 2;
  localparam int BusyW         = 2;

  typedef logic signed [DataW-1:0] word_t;
  typedef logic signed [TermW-1:0] term_t;
  typedef logic signed [MatW-1:0]  mat_entry_t;
  typedef mat_entry_t mat_t [NumOff][NumQuat];

  localparam word_t QuatOne = 32'sh4000_0000;

  typedef enum logic [RegIdxW-1:0] {
    REG_OFFSET_X = 3'd0,
    REG_OFFSET_Y = 3'd1,
    REG_OFFSET_Z = 3'd2,
    REG_QUAT_W   = 3'd3,
    REG_QUAT_I   = 3'd4,
    REG_QUAT_J   = 3'd5,
    REG_QUAT_K   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    word_t origin_dx;
    word_t origin_dy;
    word_t origin_dz;
    word_t quat_dw;
    word_t quat_di;
    word_t quat_dj;
    word_t quat_dk;
    logic  last_column;
  } in_t;

  typedef struct packed {
    word_t coord_dx;
    word_t coord_dy;
    word_t coord_dz;
    logic  saturated;
    logic  last_out;
  } out_t;

endpackage

>>> rtl/rvjc_matrix.sv
module rvjc_matrix import rvjc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [RegIdxW-1:0] cfg_index,
  input  word_t              cfg_data,
  output mat_t               mat,
  output logic               busy
);

  word_t            off_r  [NumOff];
  word_t            quat_r [NumQuat];
  term_t            term_r [NumOff][NumQuat];
  term_t            term_nxt [NumOff][NumQuat];
  mat_entry_t       mat_r  [NumOff][NumQuat];
  mat_entry_t       mat_nxt [NumOff][NumQuat];
  logic [BusyW-1:0] busy_cnt_r;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r[0]  <= '0;
      off_r[1]  <= '0;
      off_r[2]  <= '0;
      quat_r[0] <= QuatOne;
      quat_r[1] <= '0;
      quat_r[2] <= '0;
      quat_r[3] <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_OFFSET_X: off_r[0]  <= cfg_data;
        REG_OFFSET_Y: off_r[1]  <= cfg_data;
        REG_OFFSET_Z: off_r[2]  <= cfg_data;
        REG_QUAT_W:   quat_r[0] <= cfg_data;
        REG_QUAT_I:   quat_r[1] <= cfg_data;
        REG_QUAT_J:   quat_r[2] <= cfg_data;
        REG_QUAT_K:   quat_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // twelve bilinear terms, floor(d*q / 2^29)
  always_comb begin
    logic signed [2*DataW-1:0] prod;
    for (int a = 0; a < NumOff; a++) begin
      for (int b = 0; b < NumQuat; b++) begin
        prod = off_r[a] * quat_r[b];
        term_nxt[a][b] = prod[2*DataW-1:TermShift];
      end
    end
  end

  // matrix entries from the terms
  always_comb begin
    mat_entry_t e [NumOff][NumQuat];
    mat_entry_t ma, mb, mc, md, na, nc, nd;
    for (int a = 0; a < NumOff; a++) begin
      for (int b = 0; b < NumQuat; b++) begin
        e[a][b] = MatW'(term_r[a][b]);
      end
    end
    ma =  e[0][0] - e[1][3] + e[2][2];
    mb =  e[0][1] + e[1][2] + e[2][3];
    mc = -e[0][2] + e[1][1] + e[2][0];
    md = -e[0][3] - e[1][0] + e[2][1];
    na = -e[0][0] + e[1][3] - e[2][2];
    nc =  e[0][2] - e[1][1] - e[2][0];
    nd =  e[0][3] + e[1][0] - e[2][1];
    mat_nxt[0][0] = ma; mat_nxt[0][1] = mb; mat_nxt[0][2] = mc; mat_nxt[0][3] = md;
    mat_nxt[1][0] = nd; mat_nxt[1][1] = nc; mat_nxt[1][2] = mb; mat_nxt[1][3] = ma;
    mat_nxt[2][0] = mc; mat_nxt[2][1] = nd; mat_nxt[2][2] = na; mat_nxt[2][3] = mb;
  end

  // free-running recompute, two register levels behind the register file
  always_ff @(posedge clk) begin
    term_r <= term_nxt;
    mat_r  <= mat_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_cnt_r <= BusyW'(CfgBusyCycles);
    end else if (cfg_we) begin
      busy_cnt_r <= BusyW'(CfgBusyCycles);
    end else if (busy_cnt_r != '0) begin
      busy_cnt_r <= busy_cnt_r - 1'b1;
    end
  end

  assign mat  = mat_r;
  assign busy = (busy_cnt_r != '0);

endmodule

>>> rtl/rotated_vector_jacobian_column.sv
// Jacobian column of a rotated offset vector. Seven registers hold the local
// offset (Q16.16) and the frame quaternion (Q2.30); from them a 3x4 matrix of
// partial derivatives of the rotated vector by (w, i, j, k) is kept ready in
// registers. Each request is one degree-of-freedom column (origin derivative
// and quaternion derivative); the result is origin + matrix * quaternion
// derivative, saturated to 32 bits, with the last flag carried along. One
// column is taken every cycle while in_stall is low; a result passes through
// four registered stages (multiply, product align, sum, saturate); backpressure
// on the result side fills the four stages before in_stall rises. After reset
// and after every register write, the matrix is rebuilt by two register levels
// of multipliers and adders, and in_stall is held until both levels are reloaded.
module rotated_vector_jacobian_column import rvjc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // column requests
  input  logic               in_valid,
  output logic               in_stall,
  input  in_t                in_data,
  // result requests
  output logic               out_valid,
  input  logic               out_stall,
  output out_t               out_data,
  // register writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [RegIdxW-1:0] cfg_index,
  input  word_t              cfg_data
);

  localparam logic signed [SumW-1:0] SatMax = SumW'(64'sd2147483647);
  localparam logic signed [SumW-1:0] SatMin = SumW'(-64'sd2147483648);

  mat_t mat;
  logic mat_busy;
  logic in_acc;
  logic rdy1, rdy2, rdy3, rdy4;

  // configuration side: always ready, matrix rebuilt after each write
  assign cfg_ready = 1'b1;

  rvjc_matrix u_matrix (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mat       (mat),
    .busy      (mat_busy)
  );

  // stage valids
  logic v1_r, v2_r, v3_r, out_valid_r;

  // a stage moves on when it is empty or its successor moves
  assign rdy4     = !out_valid_r || !out_stall;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1 || mat_busy;
  assign in_acc   = in_valid && !in_stall;

  // ---------------------------------------------------------------
  // stage 1: split each quaternion derivative at bit 15 and multiply
  // every matrix entry by both halves (36x17 and 36x16 products)
  // ---------------------------------------------------------------
  word_t qd [NumQuat];
  word_t org_in [NumOff];

  assign qd[0] = in_data.quat_dw;
  assign qd[1] = in_data.quat_di;
  assign qd[2] = in_data.quat_dj;
  assign qd[3] = in_data.quat_dk;
  assign org_in[0] = in_data.origin_dx;
  assign org_in[1] = in_data.origin_dy;
  assign org_in[2] = in_data.origin_dz;

  logic signed [ProdAW-1:0] pa_nxt [NumOff][NumQuat];
  logic signed [ProdBW-1:0] pb_nxt [NumOff][NumQuat];
  logic signed [ProdAW-1:0] pa_r   [NumOff][NumQuat];
  logic signed [ProdBW-1:0] pb_r   [NumOff][NumQuat];
  word_t                    org1_r [NumOff];
  logic                     last1_r;

  always_comb begin
    logic signed [HiW-1:0] hi;
    logic signed [LoW:0]   lo;
    for (int r = 0; r < NumOff; r++) begin
      for (int c = 0; c < NumQuat; c++) begin
        hi = qd[c][DataW-1:LoW];
        lo = {1'b0, qd[c][LoW-1:0]};
        pa_nxt[r][c] = mat[r][c] * hi;
        pb_nxt[r][c] = mat[r][c] * lo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      pa_r    <= pa_nxt;
      pb_r    <= pb_nxt;
      org1_r  <= org_in;
      last1_r <= in_data.last_column;
    end
  end

  // ---------------------------------------------------------------
  // stage 2: recombine the halves into the exact product and take
  // floor(product / 2^30)
  // ---------------------------------------------------------------
  logic signed [ProdW-1:0] prod_nxt [NumOff][NumQuat];
  logic signed [ProdW-1:0] prod_r   [NumOff][NumQuat];
  word_t                   org2_r   [NumOff];
  logic                    last2_r;

  always_comb begin
    logic signed [FullW-1:0] full;
    for (int r = 0; r < NumOff; r++) begin
      for (int c = 0; c < NumQuat; c++) begin
        full = (FullW'(pa_r[r][c]) <<< LoW) + FullW'(pb_r[r][c]);
        prod_nxt[r][c] = full[FullW-1:ProdShift];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      prod_r  <= prod_nxt;
      org2_r  <= org1_r;
      last2_r <= last1_r;
    end
  end

  // ---------------------------------------------------------------
  // stage 3: origin plus four truncated products, exact
  // ---------------------------------------------------------------
  logic signed [SumW-1:0] sum_nxt [NumOff];
  logic signed [SumW-1:0] sum_r   [NumOff];
  logic                   last3_r;

  always_comb begin
    for (int r = 0; r < NumOff; r++) begin
      sum_nxt[r] = SumW'(org2_r[r]) + SumW'(prod_r[r][0]) + SumW'(prod_r[r][1])
                 + SumW'(prod_r[r][2]) + SumW'(prod_r[r][3]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      sum_r   <= sum_nxt;
      last3_r <= last2_r;
    end
  end

  // ---------------------------------------------------------------
  // stage 4: clamp to 32 bits into the output register
  // ---------------------------------------------------------------
  word_t sat_val [NumOff];
  logic  sat_any;
  out_t  out_nxt;
  out_t  out_r;

  always_comb begin
    sat_any = 1'b0;
    for (int r = 0; r < NumOff; r++) begin
      if (sum_r[r] > SatMax) begin
        sat_val[r] = word_t'(SatMax);
        sat_any    = 1'b1;
      end else if (sum_r[r] < SatMin) begin
        sat_val[r] = word_t'(SatMin);
        sat_any    = 1'b1;
      end else begin
        sat_val[r] = sum_r[r][DataW-1:0];
      end
    end
    out_nxt.coord_dx  = sat_val[0];
    out_nxt.coord_dy  = sat_val[1];
    out_nxt.coord_dz  = sat_val[2];
    out_nxt.saturated = sat_any;
    out_nxt.last_out  = last3_r;
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      out_r <= out_nxt;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) v1_r        <= in_acc;
      if (rdy2) v2_r        <= v1_r;
      if (rdy3) v3_r        <= v2_r;
      if (rdy4) out_valid_r <= v3_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------
  a_cfg_blocks_next: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> in_stall)
    else $error("request accepted while matrix is rebuilt");

  a_stage3_drains: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && rdy4 |=> out_valid_r)
    else $error("sum stage item lost on its way to the output register");

  a_sat_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.saturated |->
      (out_r.coord_dx == word_t'(SatMax)) || (out_r.coord_dx == word_t'(SatMin)) ||
      (out_r.coord_dy == word_t'(SatMax)) || (out_r.coord_dy == word_t'(SatMin)) ||
      (out_r.coord_dz == word_t'(SatMax)) || (out_r.coord_dz == word_t'(SatMin)))
    else $error("saturated flag set with no coordinate at a bound");

endmodule
